// ----- sv/cps_pkg.sv -----
// shared types, widths and helpers for the closest point on segment block
// no dependencies
package cps_pkg;

	localparam int CW = 32;        // coordinate width
	localparam int DW = 33;        // coordinate difference width
	localparam int PW = 64;        // product of two magnitudes
	localparam int LW = 65;        // sum of two products
	localparam int QB = 32;        // quotient bits of the projection ratio
	localparam int TW = QB + 1;    // ratio including the value one
	localparam int EW = 16;        // epsilon width

	// register indexes
	localparam logic REG_EPSILON = 1'b0;

	typedef enum logic [1:0] {
		WHICH_PROJ  = 2'd0,
		WHICH_START = 2'd1,
		WHICH_END   = 2'd2
	} which_t;

	// item sideband carried alongside the ratio math
	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic                 sx;
		logic                 sy;
		logic [CW-1:0]        mx;
		logic [CW-1:0]        my;
		which_t               which;
		logic                 full;
	} side_t;

	// magnitude of a difference, always below 2^32
	function automatic logic [CW-1:0] mag33(input logic signed [DW-1:0] d);
		logic [DW-1:0] n;
		n = d[DW-1] ? (~d + 33'd1) : d;
		return n[CW-1:0];
	endfunction

	// clamp to the 32-bit signed range
	function automatic logic signed [CW-1:0] sat36(input logic signed [35:0] v);
		if (v > 36'sh0_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -36'sh0_8000_0000)
			return -32'sh8000_0000;
		else
			return v[CW-1:0];
	endfunction

endpackage

// ----- sv/cps_front.sv -----
// front stages: differences, products, sums and case decision
// depends on cps_pkg
module cps_front import cps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] qx,
	input  logic signed [CW-1:0] qy,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic [EW-1:0]        eps,
	output logic                 out_valid,
	output side_t                out_side,
	output logic [LW-1:0]        out_dot,
	output logic [LW-1:0]        out_len2
);

	logic v_s1, v_s2, v_s3, v_s4;
	side_t side_s1, side_s2, side_s3, side_s4;
	logic [CW-1:0] maqx_s1, maqy_s1, mbqx_s1, mbqy_s1;
	logic saqx_s1, saqy_s1;
	logic [PW-1:0] pabx_s2, paby_s2, pdx_s2, pdy_s2;
	logic [PW-1:0] paqx_s2, paqy_s2, pbqx_s2, pbqy_s2;
	logic sdx_s2, sdy_s2;
	logic lt_b_s2, lt_a_s2, lt_ab_s2;
	logic [DW-1:0] sq_b_s2, sq_a_s2, sq_ab_s2;
	logic [LW-1:0] len2_s3, da_s3, db_s3;
	logic signed [LW:0] dot_s3;
	logic cb_s3, ca_s3, cab_s3;
	logic [LW-1:0] dot_s4, len2_s4;

	logic signed [DW-1:0] abx, aby, aqx, aqy, bqx, bqy;
	logic [2*EW-1:0] eps2;
	logic [CW-1:0] eps_w;
	logic signed [LW:0] tdx, tdy;
	which_t which_d;
	logic dot_in, full_d;
	side_t side_d;

	assign abx = DW'(bx) - DW'(ax);
	assign aby = DW'(by) - DW'(ay);
	assign aqx = DW'(qx) - DW'(ax);
	assign aqy = DW'(qy) - DW'(ay);
	assign bqx = DW'(qx) - DW'(bx);
	assign bqy = DW'(qy) - DW'(by);
	assign eps2 = eps * eps;
	assign eps_w = {{(CW-EW){1'b0}}, eps};

	// stage 1: differences as sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.ax    <= ax;
			side_s1.ay    <= ay;
			side_s1.bx    <= bx;
			side_s1.by    <= by;
			side_s1.sx    <= abx[DW-1];
			side_s1.sy    <= aby[DW-1];
			side_s1.mx    <= mag33(abx);
			side_s1.my    <= mag33(aby);
			side_s1.which <= WHICH_START;
			side_s1.full  <= 1'b0;
			maqx_s1 <= mag33(aqx);
			maqy_s1 <= mag33(aqy);
			saqx_s1 <= aqx[DW-1];
			saqy_s1 <= aqy[DW-1];
			mbqx_s1 <= mag33(bqx);
			mbqy_s1 <= mag33(bqy);
		end
	end

	// stage 2: products and small closeness squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2  <= side_s1;
			pabx_s2  <= side_s1.mx * side_s1.mx;
			paby_s2  <= side_s1.my * side_s1.my;
			pdx_s2   <= side_s1.mx * maqx_s1;
			pdy_s2   <= side_s1.my * maqy_s1;
			sdx_s2   <= side_s1.sx ^ saqx_s1;
			sdy_s2   <= side_s1.sy ^ saqy_s1;
			paqx_s2  <= maqx_s1 * maqx_s1;
			paqy_s2  <= maqy_s1 * maqy_s1;
			pbqx_s2  <= mbqx_s1 * mbqx_s1;
			pbqy_s2  <= mbqy_s1 * mbqy_s1;
			lt_b_s2  <= (mbqx_s1 < eps_w) && (mbqy_s1 < eps_w);
			lt_a_s2  <= (maqx_s1 < eps_w) && (maqy_s1 < eps_w);
			lt_ab_s2 <= (side_s1.mx < eps_w) && (side_s1.my < eps_w);
			sq_b_s2  <= DW'(mbqx_s1[EW-1:0] * mbqx_s1[EW-1:0])
				+ DW'(mbqy_s1[EW-1:0] * mbqy_s1[EW-1:0]);
			sq_a_s2  <= DW'(maqx_s1[EW-1:0] * maqx_s1[EW-1:0])
				+ DW'(maqy_s1[EW-1:0] * maqy_s1[EW-1:0]);
			sq_ab_s2 <= DW'(side_s1.mx[EW-1:0] * side_s1.mx[EW-1:0])
				+ DW'(side_s1.my[EW-1:0] * side_s1.my[EW-1:0]);
		end
	end

	// stage 3: wide sums and closeness tests
	assign tdx = sdx_s2 ? -$signed({2'b00, pdx_s2}) : $signed({2'b00, pdx_s2});
	assign tdy = sdy_s2 ? -$signed({2'b00, pdy_s2}) : $signed({2'b00, pdy_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			len2_s3 <= LW'(pabx_s2) + LW'(paby_s2);
			da_s3   <= LW'(paqx_s2) + LW'(paqy_s2);
			db_s3   <= LW'(pbqx_s2) + LW'(pbqy_s2);
			dot_s3  <= tdx + tdy;
			cb_s3   <= lt_b_s2 && (sq_b_s2 < DW'(eps2));
			ca_s3   <= lt_a_s2 && (sq_a_s2 < DW'(eps2));
			cab_s3  <= lt_ab_s2 && (sq_ab_s2 < DW'(eps2));
		end
	end

	// stage 4: pick the case in fixed priority order
	assign dot_in = !dot_s3[LW] && (len2_s3 >= dot_s3[LW-1:0]);

	always_comb begin
		full_d = 1'b0;
		if (cb_s3)
			which_d = WHICH_END;
		else if (ca_s3 || cab_s3)
			which_d = WHICH_START;
		else if (len2_s3 == '0)
			which_d = WHICH_START;
		else if (dot_in) begin
			which_d = WHICH_PROJ;
			full_d  = (dot_s3[LW-1:0] == len2_s3);
		end else if (da_s3 >= db_s3)
			which_d = WHICH_END;
		else
			which_d = WHICH_START;
		// sideband with the decided case
		side_d       = side_s3;
		side_d.which = which_d;
		side_d.full  = full_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4       <= side_d;
			dot_s4        <= (which_d == WHICH_PROJ && !full_d) ? dot_s3[LW-1:0] : '0;
			len2_s4       <= len2_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_side  = side_s4;
	assign out_dot   = dot_s4;
	assign out_len2  = len2_s4;

endmodule

// ----- sv/cps_divider.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on cps_pkg
module cps_divider import cps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  side_t         in_side,
	input  logic [LW-1:0] in_dot,
	input  logic [LW-1:0] in_len2,
	output logic          out_valid,
	output side_t         out_side,
	output logic [TW-1:0] out_t
);

	logic          v_q    [0:QB-1];
	side_t         side_q [0:QB-1];
	logic [LW-1:0] rem_q  [0:QB-1];
	logic [LW-1:0] len2_q [0:QB-1];
	logic [QB-1:0] quo_q  [0:QB-1];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_step
			logic          v_in;
			side_t         side_in;
			logic [LW-1:0] rem_in, len2_in;
			logic [QB-1:0] quo_in;
			logic [LW+1:0] diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign v_in    = in_valid;
				assign side_in = in_side;
				assign rem_in  = in_dot;
				assign len2_in = in_len2;
				assign quo_in  = '0;
			end else begin : g_next
				assign v_in    = v_q[k-1];
				assign side_in = side_q[k-1];
				assign rem_in  = rem_q[k-1];
				assign len2_in = len2_q[k-1];
				assign quo_in  = quo_q[k-1];
			end

			// shift in one bit and try the subtract
			assign diff = {1'b0, rem_in, 1'b0} - {2'b00, len2_in};
			assign ge   = !diff[LW+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (en) begin
					v_q[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					side_q[k] <= side_in;
					len2_q[k] <= len2_in;
					rem_q[k]  <= ge ? diff[LW-1:0] : {rem_in[LW-2:0], 1'b0};
					quo_q[k]  <= {quo_in[QB-2:0], ge};
				end
			end

			// partial remainder stays below the divisor
			a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
				v_q[k] && side_q[k].which == WHICH_PROJ && !side_q[k].full
				|-> rem_q[k] < len2_q[k])
				else $error("divider remainder out of range");
		end
	endgenerate

	assign out_valid = v_q[QB-1];
	assign out_side  = side_q[QB-1];
	assign out_t     = side_q[QB-1].full ? {1'b1, {QB{1'b0}}} : {1'b0, quo_q[QB-1]};

	// a stall freezes the last stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q[QB-1]))
		else $error("divider moved during stall");

endmodule

// ----- sv/cps_place.sv -----
// placement of the projected point, saturation and result selection
// depends on cps_pkg
module cps_place import cps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  side_t                in_side,
	input  logic [TW-1:0]        in_t,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output which_t               out_which
);

	logic          v_s1, v_s2;
	side_t         side_s1;
	logic [LW-1:0] px_s1, py_s1;
	logic [LW:0]   rx, ry;
	logic [33:0]   offx, offy;
	logic signed [35:0] sx, sy;

	// stage 1: offset products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			px_s1   <= in_side.mx * in_t;
			py_s1   <= in_side.my * in_t;
		end
	end

	// round half away from zero, then add to the start point
	assign rx   = {1'b0, px_s1} + (LW+1)'(64'h8000_0000);
	assign ry   = {1'b0, py_s1} + (LW+1)'(64'h8000_0000);
	assign offx = rx[LW:32];
	assign offy = ry[LW:32];
	assign sx   = side_s1.sx ? 36'(side_s1.ax) - $signed({2'b00, offx})
		: 36'(side_s1.ax) + $signed({2'b00, offx});
	assign sy   = side_s1.sy ? 36'(side_s1.ay) - $signed({2'b00, offy})
		: 36'(side_s1.ay) + $signed({2'b00, offy});

	// stage 2: output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_which <= side_s1.which;
			unique case (side_s1.which)
				WHICH_PROJ: begin
					out_x <= sat36(sx);
					out_y <= sat36(sy);
				end
				WHICH_END: begin
					out_x <= side_s1.bx;
					out_y <= side_s1.by;
				end
				default: begin
					out_x <= side_s1.ax;
					out_y <= side_s1.ay;
				end
			endcase
		end
	end

	assign out_valid = v_s2;

endmodule

// ----- sv/closest_point_on_segment.sv -----
// closest point on a 2d segment, signed q16.16 coordinates
// an item passes the front stages, the divider stages and the placement stages in order
// throughput: one item per cycle; the whole pipeline holds while the result is not taken
// the projection ratio comes from a 32-stage restoring divider, one bit per stage
// reset clears all valid bits and sets epsilon to 1; depends on cps_pkg and submodules
module closest_point_on_segment import cps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	// apb configuration
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	// input items
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [191:0]  s_tdata,  // query_x, query_y, start_x, start_y, end_x, end_y
	// result items
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,  // nearest_x, nearest_y
	output logic [1:0]    m_tuser   // which_case
);

	logic [EW-1:0] eps_q;
	logic adv;
	logic f_valid, d_valid;
	side_t f_side, d_side;
	logic [LW-1:0] f_dot, f_len2;
	logic [TW-1:0] d_t;
	logic signed [CW-1:0] nx, ny;
	which_t nwhich;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
		end else if (psel && penable && pwrite && paddr[2] == REG_EPSILON) begin
			eps_q <= pwdata[EW-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_EPSILON) ? {16'd0, eps_q} : 32'd0;

	// pipeline advances whenever the output slot is free or drained
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	cps_front u_front (
		.clk, .arst_n, .en(adv), .in_valid(s_tvalid),
		.qx(s_tdata[31:0]), .qy(s_tdata[63:32]),
		.ax(s_tdata[95:64]), .ay(s_tdata[127:96]),
		.bx(s_tdata[159:128]), .by(s_tdata[191:160]),
		.eps(eps_q),
		.out_valid(f_valid), .out_side(f_side), .out_dot(f_dot), .out_len2(f_len2)
	);

	cps_divider u_div (
		.clk, .arst_n, .en(adv), .in_valid(f_valid), .in_side(f_side),
		.in_dot(f_dot), .in_len2(f_len2),
		.out_valid(d_valid), .out_side(d_side), .out_t(d_t)
	);

	cps_place u_place (
		.clk, .arst_n, .en(adv), .in_valid(d_valid), .in_side(d_side), .in_t(d_t),
		.out_valid(m_tvalid), .out_x(nx), .out_y(ny), .out_which(nwhich)
	);

	assign m_tdata = {ny, nx};
	assign m_tuser = nwhich;

	// the case code never takes the unused value
	a_which: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("invalid case code on result");

endmodule
